// ===== src/gdsf_pkg.sv =====
// Shared constants and register codes for the greedy disc spacing filter.
`default_nettype none
package gdsf_pkg;

  localparam int MAX_POINTS_DEF  = 256;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int IN_COORD_W = 32;
  localparam int RADIUS_W   = 31;
  localparam int TARGET_W   = 9;
  localparam int SLOT_W     = 8;
  localparam int PLACED_W   = 9;
  localparam int THR_W      = 64;
  localparam int SPACING_W  = RADIUS_W + 1;

  localparam int S_TDATA_W = 2 * IN_COORD_W;
  localparam int M_FIELDS_W = 1 + SLOT_W + PLACED_W + 1;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PARTICLE_RADIUS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_COUNT    = 1'b1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;
  localparam logic [TARGET_W-1:0] TARGET_RESET = 9'd256;

endpackage
`default_nettype wire

// ===== src/gdsf_point_mem.sv =====
// Synchronous point store: one write port, one read port, registered read data.
`default_nettype none
module gdsf_point_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata,
  output logic                   rvalid
);
  import gdsf_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else begin
      rvalid <= re;
    end
  end

endmodule
`default_nettype wire

// ===== src/gdsf_dist_pipe.sv =====
// Three-stage squared-distance pipeline that flags a stored point closer than the spacing.
`default_nettype none
module gdsf_dist_pipe #(
  parameter int CW = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic signed [CW-1:0]        cand_x,
  input  wire logic signed [CW-1:0]        cand_y,
  input  wire logic signed [CW-1:0]        pt_x,
  input  wire logic signed [CW-1:0]        pt_y,
  input  wire logic [gdsf_pkg::THR_W-1:0]  thr,
  output logic                             hit,
  output logic                             busy
);
  import gdsf_pkg::*;

  localparam int SQ_W  = 2 * CW;
  localparam int SUM_W = SQ_W + 1;
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  logic signed [CW:0] dx, dy;
  logic [CW-1:0]      adx_next, ady_next;
  logic [CW-1:0]      adx, ady;
  logic [SQ_W-1:0]    sqx, sqy;
  logic [SUM_W-1:0]   sum;
  logic               v1, v2, v3;

  assign dx = (CW+1)'(cand_x) - (CW+1)'(pt_x);
  assign dy = (CW+1)'(cand_y) - (CW+1)'(pt_y);
  assign adx_next = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign ady_next = dy[CW] ? CW'(-dy) : dy[CW-1:0];
  assign sum = SUM_W'(sqx) + SUM_W'(sqy);

  always_ff @(posedge clk) begin
    adx <= adx_next;
    ady <= ady_next;
    sqx <= adx * adx;
    sqy <= ady * ady;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      hit <= 1'b0;
    end else begin
      v1  <= in_valid;
      v2  <= v1;
      v3  <= v2;
      hit <= v2 && (CMP_W'(sum) < CMP_W'(thr));
    end
  end

  assign busy = v1 || v2 || v3;

endmodule
`default_nettype wire

// ===== src/greedy_disc_spacing_filter_top.sv =====
// Top level: stream ports, configuration registers and the per-candidate sequencer.
//
// Usage:
//   Candidates enter on the s_ group; s_tdata carries cand_x in [31:0] and
//   cand_y in [63:32], s_tuser carries the first flag that empties the store.
//   One result per candidate leaves on the m_ group.
//   particle_radius (index 0) and target_count (index 1) are written on the
//   cfg_ channel; cfg_ready is high whenever rst is low.
// Timing:
//   With stored points to compare, each point is read from memory in turn and
//   passed through the three-stage distance pipeline before the verdict register;
//   with none (empty store, first set, or limit reached) the scan is skipped.
//   The next candidate is taken in IDLE once the result is registered.
// Reset:
//   The store is empty after rst (fill count only, no clearing pass);
//   radius resets to 1.0 and target_count to 256.
// Stall:
//   A result waits in the output register while m_tready is low; the next
//   candidate is taken and scanned meanwhile, and its result holds until the
//   register is free.
`default_nettype none
module greedy_disc_spacing_filter_top #(
  parameter int MAX_POINTS  = gdsf_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = gdsf_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // cand_x [31:0], cand_y [63:32]
  input  wire logic [gdsf_pkg::S_TDATA_W-1:0]    s_tdata,
  // first [0]
  input  wire logic                              s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // accepted [0], slot_index [8:1], placed_count [17:9], batch_full [18], zeros above
  output logic [gdsf_pkg::M_TDATA_W-1:0]         m_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [gdsf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [gdsf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gdsf_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int LIM_W  = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;

  typedef enum logic [1:0] {IDLE, SCAN, DRAIN, FINISH} state_t;

  state_t               state;
  logic [RADIUS_W-1:0]  particle_radius;
  logic [TARGET_W-1:0]  target_count;
  logic [THR_W-1:0]     thr;
  logic [SPACING_W-1:0] spacing;
  logic [CNT_W-1:0]     kept_count;
  logic [CNT_W-1:0]     work_cnt;
  logic [CNT_W-1:0]     rd_idx;
  logic signed [CW-1:0] cx, cy;
  logic                 can_place;
  logic                 close;

  logic [LIM_W-1:0]     limit;
  logic [CNT_W-1:0]     base;
  logic                 base_ok;
  logic                 acc;
  logic [CNT_W-1:0]     new_cnt;
  logic [LIM_W-1:0]     new_cnt_ext;
  logic [LIM_W-1:0]     slot_ext;
  logic [M_TDATA_W-1:0] out_word;
  logic                 out_free;

  logic                 mem_we, mem_re, mem_rvalid;
  logic [2*CW-1:0]      mem_rdata;
  logic                 hit, pipe_busy;

  assign cfg_ready = !rst;
  assign s_tready  = !rst && (state == IDLE);
  assign spacing   = {particle_radius, 1'b0};

  assign limit = (LIM_W'(target_count) < LIM_W'(MAX_POINTS)) ?
                 LIM_W'(target_count) : LIM_W'(MAX_POINTS);
  assign base    = s_tuser ? '0 : kept_count;
  assign base_ok = LIM_W'(base) < limit;

  assign out_free    = !m_tvalid || m_tready;
  assign acc         = can_place && !close;
  assign new_cnt     = acc ? work_cnt + CNT_W'(1) : work_cnt;
  assign new_cnt_ext = LIM_W'(new_cnt);
  assign slot_ext    = acc ? LIM_W'(work_cnt) : '0;
  assign out_word    = M_TDATA_W'({(new_cnt_ext >= limit), new_cnt_ext[PLACED_W-1:0],
                                   slot_ext[SLOT_W-1:0], acc});

  assign mem_we = (state == FINISH) && out_free && acc;
  assign mem_re = (state == SCAN);

  always_ff @(posedge clk) begin
    thr <= spacing * spacing;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_radius <= RADIUS_RESET;
      target_count    <= TARGET_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PARTICLE_RADIUS: particle_radius <= cfg_data[RADIUS_W-1:0];
        REG_TARGET_COUNT:    target_count    <= cfg_data[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      kept_count <= '0;
      work_cnt   <= '0;
      rd_idx     <= '0;
      can_place  <= 1'b0;
      close      <= 1'b0;
      m_tvalid   <= 1'b0;
      m_tdata    <= '0;
    end else begin
      if (m_tvalid && m_tready && state != FINISH) begin
        m_tvalid <= 1'b0;
      end
      if (hit) begin
        close <= 1'b1;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            cx        <= s_tdata[CW-1:0];
            cy        <= s_tdata[IN_COORD_W+CW-1:IN_COORD_W];
            work_cnt  <= base;
            rd_idx    <= '0;
            close     <= 1'b0;
            can_place <= base_ok;
            state     <= (base_ok && base != '0) ? SCAN : FINISH;
          end
        end
        SCAN: begin
          rd_idx <= rd_idx + CNT_W'(1);
          if (rd_idx + CNT_W'(1) == work_cnt) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (!mem_rvalid && !pipe_busy) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            kept_count <= new_cnt;
            m_tvalid   <= 1'b1;
            m_tdata    <= out_word;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  gdsf_point_mem #(
    .DEPTH  (MAX_POINTS),
    .ADDR_W (ADDR_W),
    .DATA_W (2 * CW)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .we     (mem_we),
    .waddr  (work_cnt[ADDR_W-1:0]),
    .wdata  ({cy, cx}),
    .re     (mem_re),
    .raddr  (rd_idx[ADDR_W-1:0]),
    .rdata  (mem_rdata),
    .rvalid (mem_rvalid)
  );

  gdsf_dist_pipe #(
    .CW (CW)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mem_rvalid),
    .cand_x   (cx),
    .cand_y   (cy),
    .pt_x     (mem_rdata[CW-1:0]),
    .pt_y     (mem_rdata[2*CW-1:CW]),
    .thr      (thr),
    .hit      (hit),
    .busy     (pipe_busy)
  );

endmodule
`default_nettype wire

// ===== verif/greedy_disc_spacing_filter_tb.sv =====
// Testbench for greedy_disc_spacing_filter_top: directed and random candidates checked against a predictor.
`timescale 1ns / 100ps
module tb;
  import gdsf_pkg::*;

  localparam int POINTS     = MAX_POINTS_DEF;
  localparam int STALL_PCT  = 21;
  localparam int STUCK_MAX  = 4000;
  localparam int TAIL_WAIT  = 300;
  localparam int SPAN_CAP   = 1 << 29;

  typedef struct packed {
    logic       full;
    logic [8:0] placed;
    logic [7:0] slot;
    logic       accepted;
  } verdict_t;

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     s_tvalid  = 1'b0;
  logic                     s_tready;
  logic [S_TDATA_W-1:0]     s_tdata   = '0;
  logic                     s_tuser   = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]     m_tdata;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index = REG_PARTICLE_RADIUS;
  logic [CFG_DATA_W-1:0]    cfg_data  = '0;

  greedy_disc_spacing_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic signed [31:0] pts_x [POINTS];
  logic signed [31:0] pts_y [POINTS];
  int                 pts_n;
  logic [RADIUS_W-1:0] radius_q = RADIUS_RESET;
  logic [TARGET_W-1:0] target_q = TARGET_RESET;

  verdict_t verdicts_due [$];
  verdict_t want, got;
  int       fails       = 0;
  int       stuck       = 0;
  bit       steady      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit hold_off();
    return !steady && ($urandom_range(99) < STALL_PCT);
  endfunction

  function automatic verdict_t judge_candidate(input logic signed [31:0] x,
                                               input logic signed [31:0] y,
                                               input bit first);
    verdict_t    v;
    logic [63:0] sp, thr, ux, uy;
    logic [64:0] dist2;
    longint      dx, dy;
    int          lim;
    bit          close;
    if (first) pts_n = 0;
    lim = (target_q < POINTS) ? int'(target_q) : POINTS;
    sp = {radius_q, 1'b0};
    thr = sp * sp;
    v = '0;
    close = 1'b0;
    if (pts_n < lim) begin
      for (int i = 0; i < pts_n && !close; i++) begin
        dx = longint'(x) - longint'(pts_x[i]);
        dy = longint'(y) - longint'(pts_y[i]);
        ux = (dx < 0) ? -dx : dx;
        uy = (dy < 0) ? -dy : dy;
        dist2 = {1'b0, 64'(ux * ux)} + {1'b0, 64'(uy * uy)};
        if (dist2 < {1'b0, thr}) close = 1'b1;
      end
      if (!close) begin
        pts_x[pts_n] = x;
        pts_y[pts_n] = y;
        v.slot = pts_n[7:0];
        v.accepted = 1'b1;
        pts_n++;
      end
    end
    v.placed = pts_n[8:0];
    v.full = (pts_n >= lim);
    return v;
  endfunction

  task automatic send_cand(input logic [31:0] x, input logic [31:0] y, input bit first);
    verdict_t v;
    while (hold_off()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    v = judge_candidate(x, y, first);
    verdicts_due = {verdicts_due, v};
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_PARTICLE_RADIUS) radius_q = data[RADIUS_W-1:0];
    else target_q = data[TARGET_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [RADIUS_W-1:0] r, input logic [TARGET_W-1:0] t);
    wait_results();
    write_reg(REG_PARTICLE_RADIUS, {1'b0, r});
    write_reg(REG_TARGET_COUNT, {23'd0, t});
  endtask

  function automatic int near(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // reset values: empty store, radius 1.0, equal spacing accepted
  task automatic test_reset_defaults();
    send_cand(32'd0, 32'd0, 1'b0);
    send_cand(32'h0002_0000, 32'd0, 1'b0);
    send_cand(32'h0001_0000, 32'h0001_0000, 1'b0);
    send_cand(32'hFFFE_0000, 32'd0, 1'b0);
  endtask

  task automatic test_coord_extremes();
    set_regs(31'h7FFF_FFFF, 9'd256);
    send_cand(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_cand(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_cand(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_cand(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_cand(32'd0, 32'd0, 1'b0);
    set_regs(31'd0, 9'd256);
    send_cand(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_cand(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
  endtask

  // zero target, target of one, limit lowered below the stored count
  task automatic test_batch_limits();
    set_regs(31'h0001_0000, 9'd256);
    send_cand(32'd0, 32'd0, 1'b1);
    send_cand(32'h0010_0000, 32'd0, 1'b0);
    send_cand(32'd0, 32'h0010_0000, 1'b0);
    set_regs(31'h0001_0000, 9'd2);
    send_cand(32'h0100_0000, 32'h0100_0000, 1'b0);
    set_regs(31'h0001_0000, 9'd0);
    send_cand(32'd0, 32'd0, 1'b1);
    send_cand(32'h0100_0000, 32'd0, 1'b0);
    set_regs(31'h0001_0000, 9'd1);
    send_cand(32'd0, 32'd0, 1'b1);
    send_cand(32'h4000_0000, 32'h4000_0000, 1'b0);
  endtask

  task automatic test_full_store();
    set_regs(31'd0, 9'd256);
    for (int k = 0; k < POINTS + 3; k++) send_cand($urandom, $urandom, k == 0);
  endtask

  task automatic run_cluster(input int n, input int span, input bit fresh);
    logic [31:0] bx, by;
    bx = $urandom;
    by = $urandom;
    for (int k = 0; k < n; k++)
      send_cand(bx + 32'(near(span)), by + 32'(near(span)), fresh && k == 0);
  endtask

  task automatic test_random_phase(input logic [RADIUS_W-1:0] r, input logic [TARGET_W-1:0] t,
                                   input int items, input bit quiet);
    int     sent;
    int     n;
    int     span;
    int     roll;
    longint wide;
    set_regs(r, t);
    steady = quiet;
    wide = longint'(r) * 6;
    span = (wide > SPAN_CAP) ? SPAN_CAP : ((wide < 1) ? 1 : int'(wide));
    sent = 0;
    while (sent < items) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        n = $urandom_range(1, 16);
        run_cluster(n, span, 1'b1);
      end else if (roll < 80) begin
        n = $urandom_range(1, 6);
        run_cluster(n, span, 1'b0);
      end else begin
        n = 1;
        send_cand($urandom, $urandom, $urandom_range(9) == 0);
      end
      sent += n;
      if ($urandom_range(99) < 3) wait_results();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_coord_extremes();
    test_batch_limits();
    test_full_store();
    test_random_phase(31'($urandom_range(1 << 12, 1 << 20)), 9'($urandom_range(2, 40)), 90, 1'b0);
    test_random_phase(31'd0, 9'd8, 80, 1'b0);
    test_random_phase(31'h7FFF_FFFF, 9'd256, 70, 1'b0);
    test_random_phase(31'($urandom_range(1, 1 << 18)), 9'd256, 100, 1'b1);
    test_random_phase(31'($urandom_range(1 << 10, 1 << 16)), 9'd1, 50, 1'b0);
    test_random_phase(31'($urandom_range(1 << 14, 1 << 22)), 9'($urandom_range(0, 256)),
                      90, 1'b0);
    test_random_phase(31'($urandom), 9'd0, 30, 1'b0);
    test_random_phase(31'($urandom_range(1 << 12, 1 << 18)), 9'($urandom_range(3, 30)),
                      80, 1'b0);
    wait_results();
    repeat (TAIL_WAIT) @(posedge clk);
    if (fails == 0 && verdicts_due.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // result checker and sink backpressure
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected result transaction: tdata %h", m_tdata);
        fails++;
      end else begin
        want = verdicts_due.pop_front();
        got = verdict_t'(m_tdata[M_FIELDS_W-1:0]);
        if (got.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
          fails++;
        end
        if (got.slot !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
          fails++;
        end
        if (got.placed !== want.placed) begin
          $error("placed_count: expected %0d, got %0d", want.placed, got.placed);
          fails++;
        end
        if (got.full !== want.full) begin
          $error("batch_full: expected %0d, got %0d", want.full, got.full);
          fails++;
        end
      end
    end
    m_tready <= !hold_off();
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        stuck <= 0;
      else
        stuck <= stuck + 1;
      if (stuck >= STUCK_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
